@@ sv/srw_pkg.sv @@
// ----------------------------------------------------------------------------
// srw_pkg: shared types and constants of the sequence reorder window
// Message and result formats, result kinds and the back-end state encoding.
// ----------------------------------------------------------------------------
package srw_pkg;

   localparam int SEQ_W     = 31;
   localparam int HOST_W    = 8;
   localparam int CONTENT_W = 31;
   localparam int DELIV_W   = 32;
   localparam int DIFF_W    = 33;

   // The last delivered sequence number starts one below zero.
   localparam logic [DELIV_W-1:0] DELIV_RESET = '1;

   typedef enum logic [2:0] {
      KIND_DELIVERED = 3'd0,
      KIND_STORED    = 3'd1,
      KIND_DUPLICATE = 3'd2,
      KIND_STALE     = 3'd3,
      KIND_BEYOND    = 3'd4
   } kind_type;

   typedef struct packed {
      logic [SEQ_W-1:0]     seq_num;
      logic [HOST_W-1:0]    host_id;
      logic [CONTENT_W-1:0] content;
   } req_type;

   typedef struct packed {
      kind_type             kind;
      logic [SEQ_W-1:0]     out_seq;
      logic [HOST_W-1:0]    out_host;
      logic [CONTENT_W-1:0] out_content;
      logic                 last;
   } rsp_type;

   // Classified message handed from the front end to the back end.
   typedef struct packed {
      kind_type kind;
      req_type  msg;
   } cmd_type;

   typedef enum logic [1:0] {
      BK_IDLE,
      BK_SCAN,
      BK_EMIT
   } back_state_type;

endpackage

@@ sv/sequence_reorder_window_top.sv @@
// ----------------------------------------------------------------------------
// sequence_reorder_window_top: receive-side sliding-window reorder buffer
// Messages arrive out of order and leave in sequence order.
// ----------------------------------------------------------------------------
// A message is presented on req_data and transferred when start is high and
// busy is low. Each message causes one or more results on rsp_data, each one
// valid for exactly one cycle while rsp_strobe is high; rsp_data.last marks
// the final result of a message. The receiver cannot stall the block.
// A stale, out-of-window or duplicate message, or one that is stored without
// completing a run, gives a single result. A message that closes a gap
// releases the whole contiguous run, one delivered result per cycle.
// Busy stays high after a transfer while the message is classified, queued
// and handled, so a new message is taken only once the last one is done.
// The delivery rate is set by the drain, which reads one ring
// slot per cycle from the slot memory. Results are registered and appear in
// the cycle after the internal step that forms them; the last one leaves as busy falls.
// Reset empties the window and sets the last delivered number to minus one;
// slot contents are not cleared.
// ----------------------------------------------------------------------------
module sequence_reorder_window_top #(
   parameter int WINDOW = 32
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   output logic             busy,
   input  srw_pkg::req_type req_data,
   output logic             rsp_strobe,
   output srw_pkg::rsp_type rsp_data
);

   localparam int SLOT_W  = $clog2(WINDOW);
   localparam int CMD_W   = $bits(srw_pkg::cmd_type);
   localparam int QUEUE_W = CMD_W + SLOT_W;

   logic                        take;
   logic                        front_pending;
   logic                        cmd_push, cmd_pop;
   srw_pkg::cmd_type            front_cmd, back_cmd;
   logic [SLOT_W-1:0]           front_slot, back_slot;
   logic [QUEUE_W-1:0]          queue_out;
   logic                        queue_not_empty, queue_full;
   logic [WINDOW-1:0]           valid_vec;
   logic [SLOT_W-1:0]           base_slot;
   logic [srw_pkg::DELIV_W-1:0] last_delivered;
   logic                        back_idle;

   assign take = start && !busy;
   assign busy = front_pending || queue_not_empty || queue_full || !back_idle;

   srw_front #(
      .WINDOW (WINDOW)
   ) u_front (
      .clock          (clock),
      .reset          (reset),
      .take           (take),
      .req_data       (req_data),
      .valid_vec      (valid_vec),
      .base_slot      (base_slot),
      .last_delivered (last_delivered),
      .pending        (front_pending),
      .cmd_push       (cmd_push),
      .cmd_data       (front_cmd),
      .cmd_slot       (front_slot)
   );

   srw_cmd_queue #(
      .DATA_W (QUEUE_W),
      .DEPTH  (2)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (cmd_push),
      .push_data ({front_cmd, front_slot}),
      .pop       (cmd_pop),
      .not_empty (queue_not_empty),
      .full      (queue_full),
      .pop_data  (queue_out)
   );

   assign back_cmd  = queue_out[QUEUE_W-1:SLOT_W];
   assign back_slot = queue_out[SLOT_W-1:0];

   srw_back #(
      .WINDOW (WINDOW)
   ) u_back (
      .clock          (clock),
      .reset          (reset),
      .cmd_valid      (queue_not_empty),
      .cmd_data       (back_cmd),
      .cmd_slot       (back_slot),
      .cmd_pop        (cmd_pop),
      .valid_vec      (valid_vec),
      .base_slot      (base_slot),
      .last_delivered (last_delivered),
      .idle           (back_idle),
      .rsp_strobe     (rsp_strobe),
      .rsp_data       (rsp_data)
   );

endmodule

@@ sv/srw_ram.sv @@
// ----------------------------------------------------------------------------
// srw_ram: generic single-write, single-read RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module srw_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 32
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

@@ sv/srw_cmd_queue.sv @@
// ----------------------------------------------------------------------------
// srw_cmd_queue: short command queue between front end and back end
// A small first-in first-out buffer of classified messages.
// ----------------------------------------------------------------------------
module srw_cmd_queue #(
   parameter int DATA_W = 8,
   parameter int DEPTH  = 2
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  logic [DATA_W-1:0] push_data,
   input  logic              pop,
   output logic              not_empty,
   output logic              full,
   output logic [DATA_W-1:0] pop_data
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   logic [DATA_W-1:0] entry_ff [DEPTH];
   logic [PTR_W-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic              do_push, do_pop;

   assign not_empty = (count_ff != '0);
   assign full      = (count_ff == CNT_W'(DEPTH));
   assign do_push   = push && !full;
   assign do_pop    = pop && not_empty;
   assign pop_data  = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

@@ sv/srw_front.sv @@
// ----------------------------------------------------------------------------
// srw_front: message intake and classification
// Registers an accepted message, measures its offset from the last delivered
// sequence number and tags it as stale, beyond window, duplicate or storable.
// ----------------------------------------------------------------------------
module srw_front #(
   parameter int WINDOW = 32
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        take,
   input  srw_pkg::req_type            req_data,
   input  logic [WINDOW-1:0]           valid_vec,
   input  logic [$clog2(WINDOW)-1:0]   base_slot,
   input  logic [srw_pkg::DELIV_W-1:0] last_delivered,
   output logic                        pending,
   output logic                        cmd_push,
   output srw_pkg::cmd_type            cmd_data,
   output logic [$clog2(WINDOW)-1:0]   cmd_slot
);

   localparam int SLOT_W = $clog2(WINDOW);

   srw_pkg::req_type              msg_ff;
   logic                          pend_ff, pend_in;
   logic [srw_pkg::DIFF_W-1:0]    diff;
   logic                          is_stale, is_beyond;
   logic [SLOT_W:0]               slot_sum;
   logic [SLOT_W-1:0]             slot;

   always_comb begin
      pend_in = pend_ff;
      if (take) begin
         pend_in = 1'b1;
      end else if (pend_ff) begin
         pend_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_ff <= 1'b0;
      end else begin
         pend_ff <= pend_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         msg_ff <= req_data;
      end
   end

   // The offset is exact: both operands are widened before the subtraction.
   assign diff = {2'b00, msg_ff.seq_num} - {last_delivered[srw_pkg::DELIV_W-1], last_delivered};
   assign is_stale  = diff[srw_pkg::DIFF_W-1] || (diff == '0);
   assign is_beyond = !diff[srw_pkg::DIFF_W-1] && (diff >= srw_pkg::DIFF_W'(WINDOW));

   assign slot_sum = {1'b0, base_slot} + {1'b0, diff[SLOT_W-1:0]};
   assign slot     = (slot_sum >= (SLOT_W + 1)'(WINDOW))
                     ? SLOT_W'(slot_sum - (SLOT_W + 1)'(WINDOW))
                     : slot_sum[SLOT_W-1:0];

   always_comb begin
      cmd_data.msg = msg_ff;
      if (is_stale) begin
         cmd_data.kind = srw_pkg::KIND_STALE;
      end else if (is_beyond) begin
         cmd_data.kind = srw_pkg::KIND_BEYOND;
      end else if (valid_vec[slot]) begin
         cmd_data.kind = srw_pkg::KIND_DUPLICATE;
      end else begin
         cmd_data.kind = srw_pkg::KIND_STORED;
      end
   end

   assign cmd_slot = slot;
   assign cmd_push = pend_ff;
   assign pending  = pend_ff;

endmodule

@@ sv/srw_back.sv @@
// ----------------------------------------------------------------------------
// srw_back: slot store and in-order drain
// Writes storable messages into the ring, then delivers the contiguous run of
// valid slots after the base one per cycle, and reports the other outcomes.
// ----------------------------------------------------------------------------
module srw_back #(
   parameter int WINDOW = 32
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        cmd_valid,
   input  srw_pkg::cmd_type            cmd_data,
   input  logic [$clog2(WINDOW)-1:0]   cmd_slot,
   output logic                        cmd_pop,
   output logic [WINDOW-1:0]           valid_vec,
   output logic [$clog2(WINDOW)-1:0]   base_slot,
   output logic [srw_pkg::DELIV_W-1:0] last_delivered,
   output logic                        idle,
   output logic                        rsp_strobe,
   output srw_pkg::rsp_type            rsp_data
);

   localparam int SLOT_W = $clog2(WINDOW);
   localparam int DATA_W = srw_pkg::HOST_W + srw_pkg::CONTENT_W;

   srw_pkg::back_state_type       state_ff, state_in;
   logic [WINDOW-1:0]             valid_ff, valid_in;
   logic [SLOT_W-1:0]             base_ff, base_in;
   logic [srw_pkg::DELIV_W-1:0]   deliv_ff, deliv_in;
   logic [SLOT_W-1:0]             count_ff, count_in;
   logic [srw_pkg::SEQ_W-1:0]     seq_ff, seq_in;
   logic                          strobe_ff, strobe_in;
   srw_pkg::rsp_type              rsp_ff, rsp_in;

   logic [SLOT_W-1:0]             next_slot;
   logic                          more;
   logic                          do_write, do_step;
   logic [DATA_W-1:0]             rd_data;

   assign next_slot = (base_ff == SLOT_W'(WINDOW - 1)) ? '0 : base_ff + 1'b1;
   assign more      = valid_ff[next_slot] && (count_ff != SLOT_W'(WINDOW - 1));

   srw_ram #(
      .WIDTH (DATA_W),
      .DEPTH (WINDOW)
   ) u_store (
      .clock   (clock),
      .wr_en   (do_write),
      .wr_addr (cmd_slot),
      .wr_data ({cmd_data.msg.host_id, cmd_data.msg.content}),
      .rd_addr (next_slot),
      .rd_data (rd_data)
   );

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         srw_pkg::BK_IDLE: begin
            if (cmd_valid && (cmd_data.kind == srw_pkg::KIND_STORED)) begin
               state_in = srw_pkg::BK_SCAN;
            end
         end
         srw_pkg::BK_SCAN, srw_pkg::BK_EMIT: begin
            state_in = more ? srw_pkg::BK_EMIT : srw_pkg::BK_IDLE;
         end
         default: state_in = srw_pkg::BK_IDLE;
      endcase
   end

   // Actions and the result of each state.
   always_comb begin
      cmd_pop   = 1'b0;
      do_write  = 1'b0;
      do_step   = 1'b0;
      strobe_in = 1'b0;
      rsp_in    = '0;
      seq_in    = seq_ff;
      case (state_ff)
         srw_pkg::BK_IDLE: begin
            if (cmd_valid) begin
               cmd_pop = 1'b1;
               seq_in  = cmd_data.msg.seq_num;
               if (cmd_data.kind == srw_pkg::KIND_STORED) begin
                  do_write = 1'b1;
               end else begin
                  strobe_in      = 1'b1;
                  rsp_in.kind    = cmd_data.kind;
                  rsp_in.out_seq = cmd_data.msg.seq_num;
                  rsp_in.last    = 1'b1;
               end
            end
         end
         srw_pkg::BK_SCAN: begin
            do_step = more;
            if (!more) begin
               strobe_in      = 1'b1;
               rsp_in.kind    = srw_pkg::KIND_STORED;
               rsp_in.out_seq = seq_ff;
               rsp_in.last    = 1'b1;
            end
         end
         srw_pkg::BK_EMIT: begin
            // The read data belongs to the slot released in the previous cycle.
            do_step            = more;
            strobe_in          = 1'b1;
            rsp_in.kind        = srw_pkg::KIND_DELIVERED;
            rsp_in.out_seq     = deliv_ff[srw_pkg::SEQ_W-1:0];
            rsp_in.out_host    = rd_data[DATA_W-1:srw_pkg::CONTENT_W];
            rsp_in.out_content = rd_data[srw_pkg::CONTENT_W-1:0];
            rsp_in.last        = !more;
         end
         default: begin
            strobe_in = 1'b0;
         end
      endcase
   end

   always_comb begin
      valid_in = valid_ff;
      base_in  = base_ff;
      deliv_in = deliv_ff;
      count_in = count_ff;
      if (do_write) begin
         valid_in[cmd_slot] = 1'b1;
         count_in           = '0;
      end
      if (do_step) begin
         valid_in[next_slot] = 1'b0;
         base_in             = next_slot;
         deliv_in            = deliv_ff + 1'b1;
         count_in            = count_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= srw_pkg::BK_IDLE;
         valid_ff  <= '0;
         base_ff   <= SLOT_W'(WINDOW - 1);
         deliv_ff  <= srw_pkg::DELIV_RESET;
         count_ff  <= '0;
         strobe_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         valid_ff  <= valid_in;
         base_ff   <= base_in;
         deliv_ff  <= deliv_in;
         count_ff  <= count_in;
         strobe_ff <= strobe_in;
      end
   end

   always_ff @(posedge clock) begin
      seq_ff <= seq_in;
      rsp_ff <= rsp_in;
   end

   assign valid_vec      = valid_ff;
   assign base_slot      = base_ff;
   assign last_delivered = deliv_ff;
   assign idle           = (state_ff == srw_pkg::BK_IDLE);
   assign rsp_strobe     = strobe_ff;
   assign rsp_data       = rsp_ff;

endmodule

@@ bench/tb_sequence_reorder_window_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_sequence_reorder_window_top: self-checking bench for the reorder window
// Sends messages at the command port, predicts the results of each transfer
// and compares every strobed result with the oldest pending prediction.
// Directed cases cover each result kind and the window edges. Random traffic
// then sends shuffled runs of consecutive sequence numbers, some of WINDOW - 1
// numbers, mixed with stale, out-of-window and repeated messages.
// ----------------------------------------------------------------------------
module tb_sequence_reorder_window_top;

   localparam int WINDOW       = 32;
   localparam int RANDOM_ITEMS = 420;
   localparam int STALL_LIMIT  = 4000;
   localparam int DRAIN_WAIT   = 60;

   logic             clock = 1'b0;
   logic             reset = 1'b1;
   logic             start = 1'b0;
   logic             busy;
   srw_pkg::req_type req_data = '0;
   logic             rsp_strobe;
   srw_pkg::rsp_type rsp_data;

   sequence_reorder_window_top #(
      .WINDOW(WINDOW)
   ) uut (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .req_data  (req_data),
      .rsp_strobe(rsp_strobe),
      .rsp_data  (rsp_data)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // Shadow copy of the window.
   logic [WINDOW-1:0]             held_valid = '0;
   logic [srw_pkg::HOST_W-1:0]    held_host    [WINDOW];
   logic [srw_pkg::CONTENT_W-1:0] held_content [WINDOW];
   int                            ring_base     = WINDOW - 1;
   longint                        delivered_seq = -1;

   srw_pkg::rsp_type pending_results[$];
   srw_pkg::rsp_type oldest;
   int               error_count     = 0;
   int               messages_sent   = 0;
   int               results_checked = 0;
   int               kind_count[5]   = '{default: 0};
   int               stall_cycles    = 0;
   bit               quiet_stretch   = 1'b0;

   task automatic predict_release(input srw_pkg::req_type m);
      longint           offset;
      int               slot;
      int               nxt;
      int               released;
      srw_pkg::rsp_type r;
      offset   = longint'(m.seq_num) - delivered_seq;
      released = 0;
      r        = '0;
      r.out_seq = m.seq_num;
      r.last    = 1'b1;
      if (offset <= 0) begin
         r.kind = srw_pkg::KIND_STALE;
         pending_results.push_back(r);
      end else if (offset >= WINDOW) begin
         r.kind = srw_pkg::KIND_BEYOND;
         pending_results.push_back(r);
      end else begin
         slot = (ring_base + int'(offset)) % WINDOW;
         if (held_valid[slot]) begin
            r.kind = srw_pkg::KIND_DUPLICATE;
            pending_results.push_back(r);
         end else begin
            held_valid[slot]   = 1'b1;
            held_host[slot]    = m.host_id;
            held_content[slot] = m.content;
            nxt = (ring_base + 1) % WINDOW;
            while (held_valid[nxt] && released < WINDOW - 1) begin
               held_valid[nxt] = 1'b0;
               ring_base       = nxt;
               delivered_seq   = delivered_seq + 1;
               released++;
               nxt = (ring_base + 1) % WINDOW;
               r.kind        = srw_pkg::KIND_DELIVERED;
               r.out_seq     = srw_pkg::SEQ_W'(delivered_seq);
               r.out_host    = held_host[ring_base];
               r.out_content = held_content[ring_base];
               r.last        = !held_valid[nxt] || (released >= WINDOW - 1);
               pending_results.push_back(r);
            end
            if (released == 0) begin
               r.kind = srw_pkg::KIND_STORED;
               pending_results.push_back(r);
            end
         end
      end
      if (released == 0) kind_count[int'(r.kind)]++;
      else kind_count[int'(srw_pkg::KIND_DELIVERED)] += released;
   endtask

   function automatic int pick_gap();
      int roll;
      roll = $urandom_range(0, 99);
      if (quiet_stretch || roll < 50) return 0;
      else if (roll < 85) return $urandom_range(1, 3);
      else if (roll < 97) return $urandom_range(4, 10);
      else return $urandom_range(20, 40);
   endfunction

   function automatic logic [srw_pkg::HOST_W-1:0] rand_host();
      return srw_pkg::HOST_W'($urandom());
   endfunction

   function automatic logic [srw_pkg::CONTENT_W-1:0] rand_content();
      return srw_pkg::CONTENT_W'($urandom());
   endfunction

   // Called at a falling edge; returns at a falling edge after the transfer.
   task automatic send_message(input logic [srw_pkg::SEQ_W-1:0]     seq,
                               input logic [srw_pkg::HOST_W-1:0]    host,
                               input logic [srw_pkg::CONTENT_W-1:0] cont);
      srw_pkg::req_type m;
      int               gap;
      m.seq_num = seq;
      m.host_id = host;
      m.content = cont;
      req_data <= m;
      start    <= 1'b1;
      do @(posedge clock); while (busy);
      predict_release(m);
      messages_sent++;
      @(negedge clock);
      gap = pick_gap();
      if (gap > 0) begin
         start    <= 1'b0;
         req_data <= {srw_pkg::SEQ_W'($urandom()), rand_host(), rand_content()};
         repeat (gap) @(negedge clock);
      end
   endtask

   task automatic test_result_kinds();
      send_message(31'd0, 8'h00, 31'd0);
      send_message(31'd0, 8'hFF, 31'h7FFF_FFFF);
      send_message(31'd32, 8'h5A, 31'h2AAA_AAAA);
      send_message(31'h7FFF_FFFF, 8'hFF, 31'h7FFF_FFFF);
      send_message(31'd31, 8'hFF, 31'h7FFF_FFFF);
      send_message(31'd31, 8'h00, 31'd0);
   endtask

   task automatic test_gap_closing();
      send_message(31'd1, 8'hAA, 31'h5555_5555);
      send_message(31'd3, 8'h33, 31'h1234_5678);
      send_message(31'd2, 8'hCC, 31'h0ABC_DEF0);
      send_message(31'd1, 8'h01, 31'd1);
      send_message(31'd3, 8'h03, 31'd3);
      send_message(31'd5, 8'h55, 31'h7000_0005);
      send_message(31'd4, 8'h44, 31'h0000_0004);
   endtask

   task automatic send_noise();
      logic [srw_pkg::SEQ_W-1:0] seq;
      int                        pick;
      pick = $urandom_range(0, 2);
      if (pick == 0 && delivered_seq >= 0) begin
         seq = srw_pkg::SEQ_W'($urandom_range(0, int'(delivered_seq)));
      end else if (pick == 2) begin
         seq = srw_pkg::SEQ_W'(delivered_seq + $urandom_range(1, WINDOW - 1));
      end else if ($urandom_range(0, 1) == 0) begin
         seq = srw_pkg::SEQ_W'(delivered_seq + WINDOW + $urandom_range(0, 3));
      end else begin
         seq = srw_pkg::SEQ_W'($urandom());
         seq[srw_pkg::SEQ_W-1] = 1'b1;
      end
      send_message(seq, rand_host(), rand_content());
   endtask

   // A shuffled run of the next consecutive numbers, with an occasional
   // resend of one already sent in the run.
   task automatic send_run();
      int     run_len;
      int     order[$];
      int     pick;
      int     swap;
      longint run_base;
      run_len  = ($urandom_range(0, 7) == 0) ? WINDOW - 1 : $urandom_range(1, 8);
      run_base = delivered_seq;
      order.delete();
      for (int k = 1; k <= run_len; k++) order.push_back(k);
      for (int k = run_len - 1; k > 0; k--) begin
         pick = $urandom_range(0, k);
         swap = order[k];
         order[k] = order[pick];
         order[pick] = swap;
      end
      for (int k = 0; k < run_len; k++) begin
         send_message(srw_pkg::SEQ_W'(run_base + order[k]), rand_host(), rand_content());
         if ($urandom_range(0, 9) == 0) begin
            pick = $urandom_range(0, k);
            send_message(srw_pkg::SEQ_W'(run_base + order[pick]), rand_host(),
                         rand_content());
         end
      end
   endtask

   task automatic test_random_traffic();
      int first;
      first = messages_sent;
      while (messages_sent - first < RANDOM_ITEMS) begin
         quiet_stretch = ($urandom_range(0, 5) == 0);
         if ($urandom_range(0, 9) < 7) send_run();
         else send_noise();
      end
      quiet_stretch = 1'b0;
   endtask

   always @(posedge clock) begin
      if (!reset && rsp_strobe) begin
         if (pending_results.size() == 0) begin
            error_count++;
            if (error_count <= 10)
               $display("ERROR: unexpected result kind %0d seq %0d", rsp_data.kind,
                        rsp_data.out_seq);
         end else begin
            oldest = pending_results.pop_front();
            results_checked++;
            if (rsp_data.kind !== oldest.kind || rsp_data.out_seq !== oldest.out_seq ||
                rsp_data.out_host !== oldest.out_host ||
                rsp_data.out_content !== oldest.out_content ||
                rsp_data.last !== oldest.last) begin
               error_count++;
               if (error_count <= 10) begin
                  $display("ERROR: result %0d expected kind %0d seq %0d host %0h %s",
                           results_checked, oldest.kind, oldest.out_seq,
                           oldest.out_host, "");
                  $display("       expected content %0h last %0b",
                           oldest.out_content, oldest.last);
                  $display("       got kind %0d seq %0d host %0h content %0h last %0b",
                           rsp_data.kind, rsp_data.out_seq, rsp_data.out_host,
                           rsp_data.out_content, rsp_data.last);
               end
            end
         end
      end
   end

   // Any transfer on either side restarts the count.
   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_strobe) begin
         stall_cycles <= 0;
      end else begin
         stall_cycles <= stall_cycles + 1;
         if (stall_cycles >= STALL_LIMIT) begin
            $display("FAIL sequence_reorder_window_top");
            $finish;
         end
      end
   end

   initial begin
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);
      test_result_kinds();
      test_gap_closing();
      test_random_traffic();
      start <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
      repeat (DRAIN_WAIT) @(posedge clock);
      if (pending_results.size() != 0) error_count++;
      $display("Sent %0d messages and checked %0d results.", messages_sent, results_checked);
      $display("Kinds: %0d delivered, %0d stored, %0d duplicate, %0d stale, %0d beyond window.",
               kind_count[0], kind_count[1], kind_count[2], kind_count[3], kind_count[4]);
      if (error_count == 0) begin
         $display("PASS sequence_reorder_window_top");
      end else begin
         $display("FAIL sequence_reorder_window_top");
      end
      $finish;
   end

endmodule
